FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    localparam logic             REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_SQUEEZE,
        CELL_INSERT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PACK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        cell_op_t                    op;
        logic                        restart;
        logic signed [SAMPLE_W-1:0]  sample;
    } cell_ctrl_t;

endpackage

FILE: rtl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
#(
    parameter int AGE_W = 6,
    parameter int WIN_W = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic [WIN_W-1:0]           win,
    input  logic                       left_valid,
    input  logic signed [SAMPLE_W-1:0] left_value,
    input  logic [AGE_W-1:0]           left_age,
    input  logic                       left_gt,
    input  logic                       right_valid,
    input  logic signed [SAMPLE_W-1:0] right_value,
    input  logic [AGE_W-1:0]           right_age,
    input  logic                       hole_in,
    output logic                       valid,
    output logic signed [SAMPLE_W-1:0] value,
    output logic [AGE_W-1:0]           age,
    output logic                       gt,
    output logic                       hole_out,
    output logic                       gap
);

    localparam int CW = AGE_W + WIN_W;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic [AGE_W-1:0]           age_reg;
    logic [AGE_W-1:0]           age_next;
    logic                       keep;

    assign gt       = !valid_reg || (value_reg > ctrl.sample);
    assign hole_out = hole_in || !valid_reg;
    assign gap      = hole_in && valid_reg;
    assign keep     = (CW'(age_reg) + CW'(1)) < CW'(win);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_DROP:
            begin
                valid_next = valid_reg && !ctrl.restart && keep;
                age_next   = age_reg + AGE_W'(1);
            end
            CELL_SQUEEZE:
            begin
                if (hole_out)
                begin
                    valid_next = right_valid;
                    value_next = right_value;
                    age_next   = right_age;
                end
            end
            CELL_INSERT:
            begin
                if (left_gt)
                begin
                    valid_next = left_valid;
                    value_next = left_value;
                    age_next   = left_age;
                end
                else if (gt)
                begin
                    valid_next = 1'b1;
                    value_next = ctrl.sample;
                    age_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

FILE: rtl/sliding_window_median.sv
`timescale 1ns / 1ps

// Sliding-window lower median filter.
// Input channel s_*: one signed sample per item, restart flag in s_tuser
// empties the window before that sample is taken. Output channel m_*: one
// median per item once the window holds window_size samples; the first
// window_size-1 items after reset or a restart give no result.
// The window is a row of sorted cells; each item runs through three
// phases: age and drop expired entries, close the gaps they leave (one
// gap a cycle), insert the new sample in order. The median cell is
// registered after insertion, once the output register can take it.
// A new sample is accepted only in idle, once the previous item is
// done; gaps come only from dropped entries that sat below kept ones
// (0 or 1 such entries at a steady window size).
// A result waits in the output register while m_tready is low and the
// next item is already accepted; the block stalls only if a second
// result is ready before the first is taken.
// Reset empties the window and sets window_size to 3. Program window_size
// over the APB port (address 0) only while the block is idle.

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // [31:0] sample
    input  logic                s_tuser,    // [0] restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,    // [31:0] median
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);

    state_t                     state_reg;
    state_t                     state_next;
    logic [CFG_W-1:0]           window_size_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_load;
    cell_ctrl_t                 ctrl;
    logic [WIN_W-1:0]           win;
    logic [WIN_W-1:0]           win_m1;
    logic [AGE_W-1:0]           last_idx;
    logic [AGE_W-1:0]           mid_idx;
    logic                       any_gap;
    logic                       full;

    logic                       cell_valid [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] cell_value [WINDOW_MAX];
    logic [AGE_W-1:0]           cell_age   [WINDOW_MAX];
    logic                       cell_gt    [WINDOW_MAX];
    logic                       cell_hole  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      cell_gap;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE))
        begin
            window_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win = WIN_W'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            win = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win = WIN_W'(window_size_reg);
        end
    end

    assign win_m1   = win - WIN_W'(1);
    assign last_idx = win_m1[AGE_W-1:0];
    assign mid_idx  = AGE_W'(win_m1 >> 1);
    assign any_gap  = |cell_gap;
    assign full     = cell_valid[last_idx];
    assign s_tready = (state_reg == ST_IDLE);

    generate
        for (genvar i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            logic                       l_valid;
            logic signed [SAMPLE_W-1:0] l_value;
            logic [AGE_W-1:0]           l_age;
            logic                       l_gt;
            logic                       r_valid;
            logic signed [SAMPLE_W-1:0] r_value;
            logic [AGE_W-1:0]           r_age;
            logic                       h_in;

            if (i == 0)
            begin : g_first
                assign l_valid = 1'b0;
                assign l_value = '0;
                assign l_age   = '0;
                assign l_gt    = 1'b0;
                assign h_in    = 1'b0;
            end
            else
            begin : g_inner
                assign l_valid = cell_valid[i-1];
                assign l_value = cell_value[i-1];
                assign l_age   = cell_age[i-1];
                assign l_gt    = cell_gt[i-1];
                assign h_in    = cell_hole[i-1];
            end

            if (i == WINDOW_MAX - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_value = '0;
                assign r_age   = '0;
            end
            else
            begin : g_body
                assign r_valid = cell_valid[i+1];
                assign r_value = cell_value[i+1];
                assign r_age   = cell_age[i+1];
            end

            swm_cell #(
                .AGE_W (AGE_W),
                .WIN_W (WIN_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .win         (win),
                .left_valid  (l_valid),
                .left_value  (l_value),
                .left_age    (l_age),
                .left_gt     (l_gt),
                .right_valid (r_valid),
                .right_value (r_value),
                .right_age   (r_age),
                .hole_in     (h_in),
                .valid       (cell_valid[i]),
                .value       (cell_value[i]),
                .age         (cell_age[i]),
                .gt          (cell_gt[i]),
                .hole_out    (cell_hole[i]),
                .gap         (cell_gap[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.restart   = 1'b0;
        ctrl.sample    = sample_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.op      = CELL_DROP;
                    ctrl.restart = s_tuser;
                    ctrl.sample  = s_tdata;
                    state_next   = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (any_gap)
                begin
                    ctrl.op = CELL_SQUEEZE;
                end
                else
                begin
                    ctrl.op    = CELL_INSERT;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!full)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata;
        end
        if (out_load)
        begin
            out_data_reg <= cell_value[mid_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
